/* sv/ecp_pkg.sv */
// ----------------------------------------------------------------------------
// ecp_pkg
// Shared constants, types and arithmetic step functions for the 1D Euler
// conserved-to-primitive converter.
// ----------------------------------------------------------------------------
`default_nettype none

package ecp_pkg;

  // Pipelined divider: dividend width (one quotient bit per stage), divisor width
  localparam int DIV_N = 65;
  localparam int DIV_D = 63;

  // Pipelined square root: radicand width and root width (one root bit per stage)
  localparam int SQ_W = 62;
  localparam int SQ_N = 31;

  // Configuration port address width
  localparam int CFG_AW = 3;

  localparam logic [31:0] POS_MAX   = 32'h7fff_ffff;
  localparam logic [31:0] NEG_MAX   = 32'h8000_0000;
  localparam logic [17:0] GAMMA_RST = 18'd91750;
  localparam logic [30:0] RGAS_RST  = 31'd65536;
  localparam logic [18:0] ONE_Q16   = 19'd65536;

  // Register indexes, decoded from the word address bit
  localparam logic REG_GAMMA = 1'b0;
  localparam logic REG_RGAS  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_BAD_RHO = 2'd1,
    ST_BAD_P   = 2'd2
  } status_t;

  // Per-cell sideband that travels alongside the arithmetic units.
  typedef struct packed {
    logic        v;
    logic        bad_rho;
    logic        last;
    logic        uneg;
    logic        pneg;
    logic        ppos;
    logic        snd_sat;
    logic [31:0] rho;
    logic [31:0] ene;
    logic [31:0] vel;
    logic [31:0] umag;
    logic [31:0] pres;
    logic [30:0] temp;
    logic [30:0] snd;
  } sb_t;

  typedef struct packed {
    logic [DIV_D-1:0] rem;
    logic [DIV_N-1:0] acc;
  } div_st_t;

  typedef struct packed {
    logic [SQ_W-1:0] x;
    logic [SQ_W:0]   res;
  } sq_st_t;

  // One restoring division step: the dividend shifts out of acc at the top
  // while quotient bits shift in at the bottom.
  function automatic div_st_t div_step(input logic [DIV_D-1:0] rem,
                                       input logic [DIV_N-1:0] acc,
                                       input logic [DIV_D-1:0] dvs);
    logic [DIV_D:0] trial;
    div_st_t        r;
    trial = {rem, acc[DIV_N-1]};
    if (trial >= {1'b0, dvs}) begin
      r.rem = DIV_D'(trial - {1'b0, dvs});
      r.acc = {acc[DIV_N-2:0], 1'b1};
    end else begin
      r.rem = trial[DIV_D-1:0];
      r.acc = {acc[DIV_N-2:0], 1'b0};
    end
    return r;
  endfunction

  // One digit-by-digit square root step for the given bit weight.
  function automatic sq_st_t sqrt_step(input logic [SQ_W-1:0] x,
                                       input logic [SQ_W:0]   res,
                                       input logic [SQ_W:0]   bitv);
    logic [SQ_W:0] sum;
    sq_st_t        r;
    sum = res + bitv;
    if ({1'b0, x} >= sum) begin
      r.x   = SQ_W'({1'b0, x} - sum);
      r.res = (res >> 1) + bitv;
    end else begin
      r.x   = x;
      r.res = res >> 1;
    end
    return r;
  endfunction

  // Signed 32-bit saturation from sign and magnitude.
  function automatic logic [31:0] sat_s32(input logic neg, input logic [64:0] mag);
    logic [31:0] r;
    if (neg) begin
      if (mag >= 65'(NEG_MAX)) begin
        r = NEG_MAX;
      end else begin
        r = 32'd0 - mag[31:0];
      end
    end else begin
      if (mag > 65'(POS_MAX)) begin
        r = POS_MAX;
      end else begin
        r = mag[31:0];
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* sv/ecp_div.sv */
// ----------------------------------------------------------------------------
// ecp_div
// Fully pipelined restoring divider, one quotient bit per stage. A zero
// divisor yields an all-ones quotient.
// ----------------------------------------------------------------------------
`default_nettype none

module ecp_div (
  input  wire logic                        clk,
  input  wire logic [ecp_pkg::DIV_N-1:0]   dividend,
  input  wire logic [ecp_pkg::DIV_D-1:0]   divisor,
  output logic      [ecp_pkg::DIV_N-1:0]   quotient
);

  ecp_pkg::div_st_t                  st_r  [ecp_pkg::DIV_N];
  logic [ecp_pkg::DIV_D-1:0]         dvs_r [ecp_pkg::DIV_N];

  always_ff @(posedge clk) begin
    st_r[0]  <= ecp_pkg::div_step('0, dividend, divisor);
    dvs_r[0] <= divisor;
    for (int s = 1; s < ecp_pkg::DIV_N; s++) begin
      st_r[s]  <= ecp_pkg::div_step(st_r[s-1].rem, st_r[s-1].acc, dvs_r[s-1]);
      dvs_r[s] <= dvs_r[s-1];
    end
  end

  assign quotient = st_r[ecp_pkg::DIV_N-1].acc;

endmodule

`default_nettype wire

/* sv/ecp_sqrt.sv */
// ----------------------------------------------------------------------------
// ecp_sqrt
// Fully pipelined integer square root, one root bit per stage, truncating.
// ----------------------------------------------------------------------------
`default_nettype none

module ecp_sqrt (
  input  wire logic                       clk,
  input  wire logic [ecp_pkg::SQ_W-1:0]   rad,
  output logic      [ecp_pkg::SQ_N-1:0]   root
);

  ecp_pkg::sq_st_t st_r [ecp_pkg::SQ_N];

  // Stage s handles bit weight 4^(SQ_N-1-s); the radicand is below 4^SQ_N.
  always_ff @(posedge clk) begin
    st_r[0] <= ecp_pkg::sqrt_step(rad, '0,
                 (ecp_pkg::SQ_W+1)'(1) << (ecp_pkg::SQ_W - 2));
    for (int s = 1; s < ecp_pkg::SQ_N; s++) begin
      st_r[s] <= ecp_pkg::sqrt_step(st_r[s-1].x, st_r[s-1].res,
                   (ecp_pkg::SQ_W+1)'(1) << (ecp_pkg::SQ_W - 2 - 2*s));
    end
  end

  assign root = st_r[ecp_pkg::SQ_N-1].res[ecp_pkg::SQ_N-1:0];

endmodule

`default_nettype wire

/* sv/ecp_cfg.sv */
// ----------------------------------------------------------------------------
// ecp_cfg
// APB-style register file holding gamma and the gas constant.
// ----------------------------------------------------------------------------
`default_nettype none

module ecp_cfg (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [ecp_pkg::CFG_AW-1:0]  paddr,
  input  wire logic [31:0]                 pwdata,
  output logic      [31:0]                 prdata,
  output logic                             pready,
  output logic      [17:0]                 gamma,
  output logic      [30:0]                 rgas
);

  logic [17:0] gamma_r, gamma_nxt;
  logic [30:0] rgas_r, rgas_nxt;
  logic        wr_en;

  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;

  always_comb begin
    gamma_nxt = gamma_r;
    rgas_nxt  = rgas_r;
    if (wr_en) begin
      case (paddr[2])
        ecp_pkg::REG_GAMMA: gamma_nxt = pwdata[17:0];
        ecp_pkg::REG_RGAS:  rgas_nxt  = pwdata[30:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gamma_r <= ecp_pkg::GAMMA_RST;
      rgas_r  <= ecp_pkg::RGAS_RST;
    end else begin
      gamma_r <= gamma_nxt;
      rgas_r  <= rgas_nxt;
    end
  end

  always_comb begin
    case (paddr[2])
      ecp_pkg::REG_GAMMA: prdata = {14'd0, gamma_r};
      ecp_pkg::REG_RGAS:  prdata = {1'b0, rgas_r};
      default:            prdata = '0;
    endcase
  end

  assign gamma = gamma_r;
  assign rgas  = rgas_r;

endmodule

`default_nettype wire

/* sv/euler_conserved_to_primitive.sv */
// ----------------------------------------------------------------------------
// euler_conserved_to_primitive
// Converts one cell of 1D Euler conserved variables per clock into the
// primitive variables, sound speed, temperature and Mach number.
// The pipeline holds four 65-stage dividers (two in parallel) and a
// 31-stage sqrt plus twelve single-register stages and an output register.
// Throughput: one cell per cycle; busy is always low and the receiver
// cannot stall. Synchronous active-low reset clears all valid bits and
// loads gamma = 1.4 and R = 1.0.
// ----------------------------------------------------------------------------
`default_nettype none

module euler_conserved_to_primitive (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic signed [31:0]          in_density,
  input  wire logic signed [31:0]          in_momentum,
  input  wire logic signed [31:0]          in_total_energy,
  input  wire logic                        in_last_cell,
  output logic                             out_valid,
  output logic signed [31:0]               out_density_out,
  output logic signed [31:0]               out_velocity,
  output logic signed [31:0]               out_energy_out,
  output logic signed [31:0]               out_pressure,
  output logic        [30:0]               out_sound_speed,
  output logic signed [31:0]               out_temperature,
  output logic signed [31:0]               out_mach_number,
  output logic        [1:0]                out_status,
  output logic                             out_last_cell_out,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [ecp_pkg::CFG_AW-1:0]  paddr,
  input  wire logic [31:0]                 pwdata,
  output logic      [31:0]                 prdata,
  output logic                             pready
);

  localparam int DN = ecp_pkg::DIV_N;
  localparam int SN = ecp_pkg::SQ_N;

  logic [17:0] gamma;
  logic [30:0] rgas;
  logic [18:0] gm1;
  logic [17:0] gm1mag;

  ecp_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .gamma   (gamma),
    .rgas    (rgas)
  );

  // gamma-1, signed. Keep configuration static while cells flow; unenforced.
  assign gm1    = {1'b0, gamma} - ecp_pkg::ONE_Q16;
  assign gm1mag = gm1[18] ? 18'(19'd0 - gm1) : gm1[17:0];

  assign busy = 1'b0;

  // Stage registers
  ecp_pkg::sb_t sb0_r, sb0_nxt, sb1_r, sb1_nxt, sb2_r, sb3_r, sb4_r, sb5_r;
  ecp_pkg::sb_t sb6_r, sb6_nxt, sb7_r, sb8_r, sb8_nxt, sb9_r, sb9_nxt;
  ecp_pkg::sb_t sb10_r, sb10_nxt, sb11_r, sb11_nxt;
  ecp_pkg::sb_t d1_r [DN];
  ecp_pkg::sb_t d2_r [DN];
  ecp_pkg::sb_t d3_r [SN];
  ecp_pkg::sb_t d4_r [DN];

  logic [31:0] mmag_r, mmag_nxt;
  logic [63:0] sq_r, sq_nxt;
  logic [62:0] pplo_r, pplo_nxt, pphi_r, pphi_nxt;
  logic [60:0] ke_r, ke_nxt;
  logic [94:0] ke_sum;
  logic [63:0] diff_r, diff_nxt;
  logic [62:0] dmag_r, dmag_nxt;
  logic [49:0] pa_r, pa_nxt;
  logic [48:0] pb_r, pb_nxt;
  logic [80:0] prod;
  logic [48:0] num_r, num_nxt;
  logic [61:0] den_r, den_nxt;
  logic [ecp_pkg::SQ_W-1:0] rad_r, rad_nxt;

  logic [DN-1:0] q1, q2, q3, q4;
  logic [SN-1:0] root;

  // Output registers
  logic        out_valid_r;
  logic [31:0] out_rho_r, out_vel_r, out_ene_r, out_pres_r, out_temp_r, out_mach_r;
  logic [30:0] out_snd_r;
  logic [1:0]  out_status_r;
  logic        out_last_r;
  logic [31:0] mach_nxt, vel_nxt, pres_nxt, temp_nxt;
  logic [30:0] snd_nxt;
  logic [1:0]  status_nxt;
  ecp_pkg::sb_t so;

  // Accept stage
  always_comb begin
    sb0_nxt         = '0;
    sb0_nxt.v       = start & ~busy;
    sb0_nxt.rho     = in_density;
    sb0_nxt.ene     = in_total_energy;
    sb0_nxt.last    = in_last_cell;
    sb0_nxt.uneg    = in_momentum[31];
    sb0_nxt.bad_rho = in_density[31] | (in_density == 32'sd0);
    mmag_nxt        = in_momentum[31] ? 32'd0 - in_momentum : in_momentum;
  end

  // Velocity magnitude: (|m| << 16) / rho
  ecp_div u_div_vel (
    .clk      (clk),
    .dividend ({17'd0, mmag_r, 16'd0}),
    .divisor  ({32'd0, sb0_r.rho[30:0]}),
    .quotient (q1)
  );

  always_comb begin
    sb1_nxt      = d1_r[DN-1];
    sb1_nxt.vel  = ecp_pkg::sat_s32(sb1_nxt.uneg, q1);
    sb1_nxt.umag = sb1_nxt.vel[31] ? 32'd0 - sb1_nxt.vel : sb1_nxt.vel;
  end

  // Kinetic term rho*u^2/2 and pressure
  assign sq_nxt   = {32'd0, sb1_r.umag} * {32'd0, sb1_r.umag};
  assign pplo_nxt = {32'd0, sb2_r.rho[30:0]} * {31'd0, sq_r[31:0]};
  assign pphi_nxt = {32'd0, sb2_r.rho[30:0]} * {31'd0, sq_r[63:32]};
  assign ke_sum   = {32'd0, pplo_r} + {pphi_r, 32'd0};
  assign ke_nxt   = ke_sum[93:33];
  assign diff_nxt = {{32{sb4_r.ene[31]}}, sb4_r.ene} - {3'd0, ke_r};

  always_comb begin
    sb6_nxt      = sb5_r;
    sb6_nxt.pneg = gm1[18] ^ diff_r[63];
    dmag_nxt     = diff_r[63] ? 63'(64'd0 - diff_r) : diff_r[62:0];
  end

  assign pa_nxt = {32'd0, gm1mag} * {18'd0, dmag_r[31:0]};
  assign pb_nxt = {31'd0, gm1mag} * {18'd0, dmag_r[62:32]};
  assign prod   = {31'd0, pa_r} + {pb_r, 32'd0};

  always_comb begin
    sb8_nxt      = sb7_r;
    sb8_nxt.pres = ecp_pkg::sat_s32(sb7_r.pneg, prod[80:16]);
  end

  always_comb begin
    sb9_nxt      = sb8_r;
    sb9_nxt.ppos = ~sb8_r.pres[31] & (sb8_r.pres != 32'd0);
    num_nxt      = {31'd0, gamma} * {18'd0, sb8_r.pres[30:0]};
    den_nxt      = {31'd0, rgas} * {31'd0, sb8_r.rho[30:0]};
  end

  // gamma*p*2^16 / rho feeds the square root; p*2^32 / (R*rho) is temperature.
  ecp_div u_div_rad (
    .clk      (clk),
    .dividend ({num_r, 16'd0}),
    .divisor  ({32'd0, sb9_r.rho[30:0]}),
    .quotient (q2)
  );

  ecp_div u_div_temp (
    .clk      (clk),
    .dividend ({2'd0, sb9_r.pres[30:0], 32'd0}),
    .divisor  ({1'b0, den_r}),
    .quotient (q3)
  );

  always_comb begin
    sb10_nxt         = d2_r[DN-1];
    sb10_nxt.snd_sat = q2[64:62] != 3'd0;
    rad_nxt          = q2[61:0];
    sb10_nxt.temp    = (q3[64:31] != '0) ? ecp_pkg::POS_MAX[30:0] : q3[30:0];
  end

  ecp_sqrt u_sqrt (
    .clk  (clk),
    .rad  (rad_r),
    .root (root)
  );

  always_comb begin
    sb11_nxt     = d3_r[SN-1];
    sb11_nxt.snd = sb11_nxt.snd_sat ? ecp_pkg::POS_MAX[30:0] : root;
  end

  // Mach magnitude: (|u| << 16) / c
  ecp_div u_div_mach (
    .clk      (clk),
    .dividend ({17'd0, sb11_r.umag, 16'd0}),
    .divisor  ({32'd0, sb11_r.snd}),
    .quotient (q4)
  );

  always_comb begin
    so       = d4_r[DN-1];
    // A zero sound speed divides to all ones, which saturates by sign.
    mach_nxt = (so.umag == 32'd0) ? 32'd0 : ecp_pkg::sat_s32(so.uneg, q4);
    vel_nxt  = so.vel;
    pres_nxt = so.pres;
    snd_nxt  = so.snd;
    temp_nxt = {1'b0, so.temp};
    status_nxt = ecp_pkg::ST_OK;
    if (so.bad_rho) begin
      status_nxt = ecp_pkg::ST_BAD_RHO;
      vel_nxt    = '0;
      pres_nxt   = '0;
      snd_nxt    = '0;
      temp_nxt   = '0;
      mach_nxt   = '0;
    end else if (!so.ppos) begin
      status_nxt = ecp_pkg::ST_BAD_P;
      snd_nxt    = '0;
      temp_nxt   = '0;
      mach_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sb0_r  <= '0;
      sb1_r  <= '0;
      sb2_r  <= '0;
      sb3_r  <= '0;
      sb4_r  <= '0;
      sb5_r  <= '0;
      sb6_r  <= '0;
      sb7_r  <= '0;
      sb8_r  <= '0;
      sb9_r  <= '0;
      sb10_r <= '0;
      sb11_r <= '0;
      for (int i = 0; i < DN; i++) begin
        d1_r[i] <= '0;
        d2_r[i] <= '0;
        d4_r[i] <= '0;
      end
      for (int i = 0; i < SN; i++) begin
        d3_r[i] <= '0;
      end
      out_valid_r <= 1'b0;
    end else begin
      sb0_r  <= sb0_nxt;
      sb1_r  <= sb1_nxt;
      sb2_r  <= sb1_r;
      sb3_r  <= sb2_r;
      sb4_r  <= sb3_r;
      sb5_r  <= sb4_r;
      sb6_r  <= sb6_nxt;
      sb7_r  <= sb6_r;
      sb8_r  <= sb8_nxt;
      sb9_r  <= sb9_nxt;
      sb10_r <= sb10_nxt;
      sb11_r <= sb11_nxt;
      d1_r[0] <= sb0_r;
      d2_r[0] <= sb9_r;
      d3_r[0] <= sb10_r;
      d4_r[0] <= sb11_r;
      for (int i = 1; i < DN; i++) begin
        d1_r[i] <= d1_r[i-1];
        d2_r[i] <= d2_r[i-1];
        d4_r[i] <= d4_r[i-1];
      end
      for (int i = 1; i < SN; i++) begin
        d3_r[i] <= d3_r[i-1];
      end
      out_valid_r <= so.v;
    end
  end

  // Datapath registers without reset
  always_ff @(posedge clk) begin
    mmag_r <= mmag_nxt;
    sq_r   <= sq_nxt;
    pplo_r <= pplo_nxt;
    pphi_r <= pphi_nxt;
    ke_r   <= ke_nxt;
    diff_r <= diff_nxt;
    dmag_r <= dmag_nxt;
    pa_r   <= pa_nxt;
    pb_r   <= pb_nxt;
    num_r  <= num_nxt;
    den_r  <= den_nxt;
    rad_r  <= rad_nxt;
    out_rho_r    <= so.rho;
    out_ene_r    <= so.ene;
    out_vel_r    <= vel_nxt;
    out_pres_r   <= pres_nxt;
    out_snd_r    <= snd_nxt;
    out_temp_r   <= temp_nxt;
    out_mach_r   <= mach_nxt;
    out_status_r <= status_nxt;
    out_last_r   <= so.last;
  end

  assign out_valid         = out_valid_r;
  assign out_density_out   = out_rho_r;
  assign out_velocity      = out_vel_r;
  assign out_energy_out    = out_ene_r;
  assign out_pressure      = out_pres_r;
  assign out_sound_speed   = out_snd_r;
  assign out_temperature   = out_temp_r;
  assign out_mach_number   = out_mach_r;
  assign out_status        = out_status_r;
  assign out_last_cell_out = out_last_r;

endmodule

`default_nettype wire
